### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### sv/bpc_pkg.sv
package bpc_pkg;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [2:0] REG_OSS     = 3'd0;
    localparam logic [2:0] REG_AC1_AC2 = 3'd1;
    localparam logic [2:0] REG_AC3_AC4 = 3'd2;
    localparam logic [2:0] REG_AC5_AC6 = 3'd3;
    localparam logic [2:0] REG_B1_B2   = 3'd4;
    localparam logic [2:0] REG_MC_MD   = 3'd5;

    localparam logic [31:0] RESET_AC1_AC2 = 32'd26804152;
    localparam logic [31:0] RESET_AC3_AC4 = 32'd3352395749;
    localparam logic [31:0] RESET_AC5_AC6 = 32'd2146785905;
    localparam logic [31:0] RESET_B1_B2   = 32'd405667844;
    localparam logic [31:0] RESET_MC_MD   = 32'd3724086068;

    // Request and reply between the sequencer and the bit-serial unit.
    typedef enum logic [1:0] {
        UOP_MUL = 2'b01,
        UOP_DIV = 2'b10
    } uop_t;

    typedef struct packed {
        logic        start;
        uop_t        op;
    } unit_req_t;

    typedef struct packed {
        logic        done;
    } unit_rsp_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### sv/bpc_serial_unit.sv
`include "assert_macros.svh"
// Bit-serial 32x32 wrapping multiply and 32/32 unsigned restoring divide,
// one bit per cycle.
module bpc_serial_unit
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  unit_req_t   req,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output unit_rsp_t   rsp,
    output logic [31:0] result
);

    logic        busy_reg, busy_next;
    uop_t        op_reg, op_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] acc_reg, acc_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    assign trial = {acc_reg, a_reg[31]} - {1'b0, b_reg};

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            a_next    = opa;
            b_next    = opb;
            acc_next  = '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                UOP_MUL: begin
                    // shift multiplicand up, add when multiplier bit set
                    if (b_reg[0]) begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[30:0], 1'b0};
                    b_next = {1'b0, b_reg[31:1]};
                end
                UOP_DIV: begin
                    // acc holds remainder, a shifts out dividend and collects quotient
                    if (!trial[32]) begin
                        acc_next = trial[31:0];
                        a_next   = {a_reg[30:0], 1'b1};
                    end else begin
                        acc_next = {acc_reg[30:0], a_reg[31]};
                        a_next   = {a_reg[30:0], 1'b0};
                    end
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= UOP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign result   = (op_reg == UOP_DIV) ? a_reg : acc_reg;

    `ASSERT_IMP(a_no_start_busy, aclk, aresetn, !(req.start && busy_reg))
    `ASSERT_NEXT(a_done_after_last, aclk, aresetn,
        busy_reg && !req.start && cnt_reg == 5'd31, rsp.done)
    `ASSERT_IMP(a_done_idle, aclk, aresetn, !(rsp.done && busy_reg))

endmodule

### sv/barometric_pressure_compensation.sv
// Channel  | dir | handshake        | payload
// s_axis   | in  | tvalid/tready    | tdata[23:0] raw_value, tuser opcode
// m_axis   | out | tvalid/tready    | tdata[31:0] value, tuser[1:0] {div_error, kind}
// cfg      | in  | cfg_we           | cfg_index, cfg_data
// One item at a time. Each multiply or divide in the shared bit-serial unit
// passes through issue, bit shifting, done and taking the result. A temperature
// item takes one multiply and one divide, a pressure item ten multiplies and
// one divide; a zero divisor ends the item early, before its divide. Reset
// (synchronous, aresetn low) restores calibration defaults and clears the offset
// term. A result waits in the output register; the next item is taken only
// once that result has left.
`include "assert_macros.svh"
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] raw_value
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] div_error
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic        op_reg, op_next;
    logic [23:0] raw_reg, raw_next;
    logic [1:0]  oss_reg;
    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [31:0] b5_reg, b5_next;
    logic [31:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [31:0] t3_reg, t3_next;
    logic        neg_reg, neg_next;
    logic [31:0] out_val_reg, out_val_next;
    logic        out_err_reg, out_err_next;
    logic        out_valid_reg, out_valid_next;

    unit_req_t   ureq;
    unit_rsp_t   ursp;
    logic [31:0] ua, ub, ures;

    bpc_serial_unit u_unit (
        .aclk(aclk), .aresetn(aresetn), .req(ureq), .opa(ua), .opb(ub),
        .rsp(ursp), .result(ures)
    );

    // calibration fields
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(ac12_reg[31:16]);
    assign ac2 = sx16(ac12_reg[15:0]);
    assign ac3 = sx16(ac34_reg[31:16]);
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = sx16(b12_reg[31:16]);
    assign b2  = sx16(b12_reg[15:0]);
    assign mc  = sx16(mcmd_reg[31:16]);
    assign md  = sx16(mcmd_reg[15:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oss_reg  <= 2'd0;
            ac12_reg <= RESET_AC1_AC2;
            ac34_reg <= RESET_AC3_AC4;
            ac56_reg <= RESET_AC5_AC6;
            b12_reg  <= RESET_B1_B2;
            mcmd_reg <= RESET_MC_MD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OSS:     oss_reg  <= cfg_data[1:0];
                REG_AC1_AC2: ac12_reg <= cfg_data;
                REG_AC3_AC4: ac34_reg <= cfg_data;
                REG_AC5_AC6: ac56_reg <= cfg_data;
                REG_B1_B2:   b12_reg  <= cfg_data;
                REG_MC_MD:   mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Step program. Temperature: 0 mul, 1 div. Pressure: 0..10 as below.
    logic [31:0] abs_n, abs_d, up, b3;
    logic [31:0] sdiv_q;
    always_comb begin
        abs_n  = t0_reg[31] ? 32'(-t0_reg) : t0_reg;
        abs_d  = t1_reg[31] ? 32'(-t1_reg) : t1_reg;
        up     = {8'd0, raw_reg} >> (4'd8 - {2'b0, oss_reg});
        b3     = asr32(((32'(ac1 << 2) + t2_reg) << oss_reg) + 32'd2, 5'd2);
        sdiv_q = neg_reg ? 32'(-ures) : ures;
    end

    always_comb begin
        ureq.start = 1'b0;
        ureq.op    = UOP_MUL;
        ua = '0;
        ub = '0;
        if (state_reg == ST_ISSUE) begin
            ureq.start = 1'b1;
            if (op_reg == OP_TEMP) begin
                unique case (step_reg)
                    5'd0: begin ua = {16'd0, raw_reg[15:0]} - ac6; ub = ac5; end
                    default: begin ureq.op = UOP_DIV; ua = abs_n; ub = abs_d; end
                endcase
            end else begin
                unique case (step_reg)
                    5'd0: begin ua = t0_reg; ub = t0_reg; end          // b6*b6
                    5'd1: begin ua = b2; ub = t1_reg; end              // b2*sq
                    5'd2: begin ua = ac2; ub = t0_reg; end             // ac2*b6
                    5'd3: begin ua = ac3; ub = t0_reg; end             // ac3*b6
                    5'd4: begin ua = b1; ub = t1_reg; end              // b1*sq
                    5'd5: begin ua = ac4; ub = t3_reg; end             // ac4*(x3+32768)
                    5'd6: begin ua = t2_reg; ub = 32'd50000 >> oss_reg; end
                    5'd7: begin ureq.op = UOP_DIV; ua = t0_reg; ub = t1_reg; end
                    5'd8: begin ua = t0_reg; ub = t0_reg; end          // x1*x1
                    5'd9: begin ua = t1_reg; ub = 32'd3038; end
                    default: begin ua = 32'hFFFF_E343; ub = t0_reg; end // -7357*p
                endcase
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        op_next      = op_reg;
        raw_next     = raw_reg;
        b5_next      = b5_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        neg_next     = neg_reg;
        out_val_next = out_val_reg;
        out_err_next = out_err_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && !out_valid_reg) begin
                    op_next    = s_axis_tuser;
                    raw_next   = s_axis_tdata;
                    step_next  = '0;
                    t0_next    = b5_reg - 32'd4000;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (ursp.done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = ST_ISSUE;
                step_next  = step_reg + 5'd1;
                if (op_reg == OP_TEMP) begin
                    if (step_reg == 5'd0) begin
                        // t2 = x1; set up signed divide of mc<<11 by x1+md
                        t2_next  = asr32(ures, 5'd15);
                        t0_next  = 32'(mc << 11);
                        t1_next  = asr32(ures, 5'd15) + md;
                        neg_next = mc[31] ^ t1_next[31];
                        if (t1_next == 32'd0) begin
                            out_err_next = 1'b1;
                            out_val_next = '0;
                            state_next   = ST_OUT;
                        end
                    end else begin
                        b5_next      = t2_reg + sdiv_q;
                        out_err_next = 1'b0;
                        out_val_next = asr32(t2_reg + sdiv_q + 32'd8, 5'd4);
                        state_next   = ST_OUT;
                    end
                end else begin
                    unique case (step_reg)
                        5'd0: t1_next = asr32(ures, 5'd12);          // sq
                        5'd1: t2_next = asr32(ures, 5'd11);          // x1
                        5'd2: t2_next = t2_reg + asr32(ures, 5'd11); // x3
                        5'd3: t3_next = asr32(ures, 5'd13);
                        5'd4: t3_next = asr32(t3_reg + asr32(ures, 5'd16) + 32'd2, 5'd2)
                                        + 32'd32768;
                        5'd5: begin
                            t3_next = ures >> 15;                    // b4
                            t2_next = up - b3;
                        end
                        5'd6: begin
                            // b7 in t0, b4 in t1
                            t1_next = t3_reg;
                            t0_next = ures[31] ? ures : {ures[30:0], 1'b0};
                            neg_next = ures[31];
                            if (t3_reg == 32'd0) begin
                                out_err_next = 1'b1;
                                out_val_next = '0;
                                state_next   = ST_OUT;
                            end
                        end
                        5'd7: begin
                            t0_next = neg_reg ? {ures[30:0], 1'b0} : ures; // p
                            t3_next = neg_reg ? {ures[30:0], 1'b0} : ures;
                        end
                        5'd8: begin
                            t1_next = ures;                          // x1*x1
                            t0_next = asr32(t3_reg, 5'd8);
                        end
                        5'd9: begin
                            t2_next = asr32(ures, 5'd16);
                            t0_next = t3_reg;
                        end
                        default: begin
                            out_err_next = 1'b0;
                            out_val_next = t3_reg +
                                asr32(t2_reg + asr32(ures, 5'd16) + 32'd3791, 5'd4);
                            state_next = ST_OUT;
                        end
                    endcase
                    // step 8 squares asr(p,8): fix operand setup
                    if (step_reg == 5'd7) begin
                        t0_next = asr32(neg_reg ? {ures[30:0], 1'b0} : ures, 5'd8);
                    end
                    if (step_reg == 5'd8) begin
                        t0_next = t0_reg;
                    end
                end
            end
            ST_OUT: begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            b5_reg        <= '0;
            step_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            b5_reg        <= b5_next;
            step_reg      <= step_next;
        end
        op_reg      <= op_next;
        raw_reg     <= raw_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        neg_reg     <= neg_next;
        out_val_reg <= out_val_next;
        out_err_reg <= out_err_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_val_reg;
    assign m_axis_tuser  = {out_err_reg, op_reg};

    `ASSERT_IMP(a_err_zero, aclk, aresetn,
        !(m_axis_tvalid && m_axis_tuser[1] && m_axis_tdata != 32'd0))
    `ASSERT_IMP(a_no_take_while_full, aclk, aresetn, !(s_axis_tready && m_axis_tvalid))
    `ASSERT_NEXT(a_out_then_idle, aclk, aresetn, state_reg == ST_OUT, m_axis_tvalid)

endmodule

### verif/tb_barometric_pressure_compensation.sv
module tb_barometric_pressure_compensation;
    import bpc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [23:0] raw_value
    logic        s_axis_tuser = 1'b0; // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] value
    logic [1:0]  m_axis_tuser;        // [0] kind, [1] div_error
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_OSS;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        div_error;
    } reading_t;

    barometric_pressure_compensation dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: calibration shadow and the stored offset term (b5).
    logic [1:0]  oss_q;
    logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q, b5_q;
    reading_t    expected_q[$];
    int          n_mismatch = 0;
    int          n_checked = 0;
    int          n_temp = 0, n_press = 0, n_err = 0;
    bit          hold_off = 1'b0;   // long receiver stall request
    int          hold_cycles = 0;

    function automatic logic [31:0] shr_s(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compensate one raw reading; updates the offset term on a good temperature.
    function automatic reading_t compensate(input logic op, input logic [23:0] raw);
        reading_t r;
        logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, up, p;
        longint q;
        r.kind = op;
        r.value = '0;
        r.div_error = 1'b0;
        if (op == OP_TEMP) begin
            x1 = shr_s(({16'd0, raw[15:0]} - {16'd0, ac56_q[15:0]}) * {16'd0, ac56_q[31:16]},
                       15);
            den = x1 + ext16(mcmd_q[15:0]);
            if (den == 0) begin
                r.div_error = 1'b1;
            end else begin
                // Truncating divide; most negative / -1 wraps by the cast.
                q = longint'($signed(ext16(mcmd_q[31:16]) << 11)) / longint'($signed(den));
                x2 = q[31:0];
                b5_q = x1 + x2;
                r.value = shr_s(b5_q + 32'd8, 4);
            end
        end else begin
            b6 = b5_q - 32'd4000;
            sq = shr_s(b6 * b6, 12);
            x1 = shr_s(ext16(b12_q[15:0]) * sq, 11);
            x2 = shr_s(ext16(ac12_q[15:0]) * b6, 11);
            x3 = x1 + x2;
            b3 = shr_s(((ext16(ac12_q[31:16]) * 32'd4 + x3) << oss_q) + 32'd2, 2);
            x1 = shr_s(ext16(ac34_q[31:16]) * b6, 13);
            x2 = shr_s(ext16(b12_q[31:16]) * sq, 16);
            x3 = shr_s(x1 + x2 + 32'd2, 2);
            b4 = ({16'd0, ac34_q[15:0]} * (x3 + 32'd32768)) >> 15;
            up = {8'd0, raw} >> (8 - oss_q);
            b7 = (up - b3) * (32'd50000 >> oss_q);
            if (b4 == 0) begin
                r.div_error = 1'b1;
            end else begin
                if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
                else p = (b7 / b4) << 1;
                x1 = shr_s(p, 8);
                x1 = x1 * x1;
                x1 = shr_s(x1 * 32'd3038, 16);
                x2 = shr_s((32'd0 - 32'd7357) * p, 16);
                p = p + shr_s(x1 + x2 + 32'd3791, 4);
                r.value = p;
            end
        end
        return r;
    endfunction

    // Apply one register write on the block and in the shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_OSS:     oss_q = val[1:0];
            REG_AC1_AC2: ac12_q = val;
            REG_AC3_AC4: ac34_q = val;
            REG_AC5_AC6: ac56_q = val;
            REG_B1_B2:   b12_q = val;
            REG_MC_MD:   mcmd_q = val;
            default: ;
        endcase
    endtask

    // Offer one beat at the falling edge; hold until accepted at a rising edge.
    task automatic send_reading(input logic op, input logic [23:0] raw);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= raw;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_q.push_back(compensate(op, raw));
        if (op == OP_TEMP) n_temp++; else n_press++;
        @(negedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Wait for every outstanding beat, then for the block to settle.
    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
    endtask

    task automatic send_burst_random(input int count, input int temp_pct);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                if ($urandom_range(99) < temp_pct)
                    send_reading(OP_TEMP, 24'($urandom));
                else
                    send_reading(OP_PRESS, 24'($urandom));
                burst--;
                left--;
            end
            if ($urandom_range(3) != 0) idle_sender($urandom_range(0, 80));
        end
    endtask

    // Datasheet-like temperature raw readings keep b5 in a realistic range.
    function automatic logic [23:0] plausible_temp();
        return {8'($urandom), 16'($urandom_range(20000, 32000))};
    endfunction

    task automatic test_reset_defaults;
        send_reading(OP_PRESS, 24'h5D_23_00);     // pressure before any temperature
        send_reading(OP_TEMP, 24'h00_6C_FA);
        send_reading(OP_PRESS, 24'h5D_23_00);
        send_reading(OP_TEMP, 24'hFF_6C_FA);      // high bits ignored
        send_reading(OP_TEMP, 24'h00_0000);
        send_reading(OP_TEMP, 24'hFF_FFFF);
        send_reading(OP_PRESS, 24'h00_0000);
        send_reading(OP_PRESS, 24'hFF_FFFF);
        send_reading(OP_PRESS, 24'hAA_5555);
        drain();
    endtask

    task automatic test_oversampling_extremes;
        for (int o = 0; o < 4; o++) begin
            write_reg(REG_OSS, 32'(o));
            send_reading(OP_TEMP, 24'h00_6C_FA);
            send_reading(OP_PRESS, 24'hFF_FFFF);
            send_reading(OP_PRESS, 24'h5D_2300);
            drain();
        end
        write_reg(REG_OSS, 32'hFFFF_FFFC);     // only the low bits count
        send_reading(OP_PRESS, 24'h80_0000);
        drain();
    endtask

    task automatic test_zero_divisors;
        // ac5 = 0 makes x1 = 0, md = 0 gives a zero temperature divisor.
        write_reg(REG_AC5_AC6, 32'h0000_1234);
        write_reg(REG_MC_MD, 32'h8000_0000);
        send_reading(OP_TEMP, 24'h00_1234);
        send_reading(OP_PRESS, 24'h12_3456);    // b5 must stay unchanged
        drain();
        // ac4 = 0 forces a zero pressure divisor.
        write_reg(REG_AC3_AC4, 32'hC000_0000);
        send_reading(OP_PRESS, 24'h12_3456);
        drain();
        // mc = -32768 shifted makes the most negative numerator; md = -1.
        write_reg(REG_MC_MD, 32'h0000_FFFF);
        write_reg(REG_MC_MD, 32'h8000_FFFF);
        send_reading(OP_TEMP, 24'h00_1234);
        drain();
    endtask

    task automatic test_random_calibration;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_OSS, 32'($urandom_range(0, 3)));
            write_reg(REG_AC1_AC2, ph == 0 ? 32'hFFFF_FFFF : $urandom);
            write_reg(REG_AC3_AC4, ph == 0 ? 32'h0000_0000 : $urandom);
            write_reg(REG_AC5_AC6, ph == 1 ? 32'hFFFF_FFFF : $urandom);
            write_reg(REG_B1_B2, ph == 1 ? 32'h8000_8000 : $urandom);
            write_reg(REG_MC_MD, ph == 2 ? 32'h7FFF_7FFF : $urandom);
            send_burst_random(25, 40);
            drain();
        end
    endtask

    task automatic test_realistic_sequences;
        write_reg(REG_AC1_AC2, RESET_AC1_AC2);
        write_reg(REG_AC3_AC4, RESET_AC3_AC4);
        write_reg(REG_AC5_AC6, RESET_AC5_AC6);
        write_reg(REG_B1_B2, RESET_B1_B2);
        write_reg(REG_MC_MD, RESET_MC_MD);
        for (int o = 0; o < 4; o++) begin
            write_reg(REG_OSS, 32'(o));
            for (int k = 0; k < 25; k++) begin
                send_reading(OP_TEMP, plausible_temp());
                repeat ($urandom_range(1, 3))
                    send_reading(OP_PRESS, {8'($urandom_range(0, 255)),
                                            8'($urandom), 8'($urandom)});
                if ($urandom_range(4) == 0) idle_sender($urandom_range(1, 60));
            end
            drain();
        end
    endtask

    task automatic test_backpressure;
        // Receiver holds off while the sender keeps offering beats.
        hold_cycles = 2000;
        hold_off = 1'b1;
        send_burst_random(8, 50);
        wait (!hold_off);
        drain();
        // Sender pauses until everything has come back, then resumes.
        send_burst_random(6, 50);
        drain();
        send_burst_random(6, 50);
        drain();
    endtask

    // Receiver: random stall pattern, plus the long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_off = 1'b0;
            end else if ($urandom_range(7) < 5) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(15) == 0) ? 1'b1 : 1'b0;
            end
        end
    end

    // Check each accepted beat against the oldest expectation.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected beat: value %h tuser %b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.div_error) n_err++;
                if (m_axis_tuser[0] !== want.kind || m_axis_tdata !== want.value
                        || m_axis_tuser[1] !== want.div_error) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp kind %b value %h err %b, ",
                                  "got kind %b value %h err %b"},
                                 want.kind, want.value, want.div_error,
                                 m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_barometric_pressure_compensation: errors");
        $finish;
    end

    initial begin
        oss_q = 2'd0;
        ac12_q = RESET_AC1_AC2;
        ac34_q = RESET_AC3_AC4;
        ac56_q = RESET_AC5_AC6;
        b12_q = RESET_B1_B2;
        mcmd_q = RESET_MC_MD;
        b5_q = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_oversampling_extremes();
        test_zero_divisors();
        test_random_calibration();
        test_realistic_sequences();
        test_backpressure();

        if (expected_q.size() != 0) n_mismatch += expected_q.size();
        $display("covered %0d temperature and %0d pressure readings, %0d zero-divisor results",
                 n_temp, n_press, n_err);
        $display("checked %0d beats across all oversampling settings, %0d mismatches",
                 n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("tb_barometric_pressure_compensation: clean");
        end else begin
            $display("tb_barometric_pressure_compensation: errors");
        end
        $finish;
    end

endmodule
